@@ hdl/obs_pkg.sv @@
// ============================================================================
// obs_pkg
// Shared types, register indexes and reset values of the oriented box sampler.
// ============================================================================
`default_nettype none

package obs_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CENTER      = 3'd0,
        REG_EXTENT      = 3'd1,
        REG_AXIS_FIRST  = 3'd2,
        REG_AXIS_SECOND = 3'd3,
        REG_AXIS_THIRD  = 3'd4
    } reg_idx_t;

    // sample function codes
    typedef enum logic [1:0] {
        FUNC_INTERIOR = 2'd0,
        FUNC_SURFACE  = 2'd1,
        FUNC_NORMAL   = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 48;

    // reset values: centre at origin, half sizes 0.5, identity axes
    localparam logic [47:0] CENTER_RESET      = 48'h0000_0000_0000;
    localparam logic [47:0] EXTENT_RESET      = 48'h0080_0080_0080;
    localparam logic [47:0] AXIS_FIRST_RESET  = 48'h0000_0000_4000;
    localparam logic [47:0] AXIS_SECOND_RESET = 48'h0000_4000_0000;
    localparam logic [47:0] AXIS_THIRD_RESET  = 48'h4000_0000_0000;

    // signed fraction 2r-1 with 16 fraction bits
    typedef logic signed [16:0] frac_t;
    // local offset with 24 fraction bits
    typedef logic signed [32:0] off_t;
    // axis normal in signed Q2.16
    typedef logic signed [18:0] nrm_t;
    // offset times axis component, 38 fraction bits
    typedef logic signed [47:0] prod_t;
    // sum of three products and the centre
    typedef logic signed [50:0] acc_t;

    // box settings, x in index 0
    typedef struct packed {
        logic [2:0][15:0] center;
        logic [2:0][15:0] extent;
        logic [2:0][15:0] axis_first;
        logic [2:0][15:0] axis_second;
        logic [2:0][15:0] axis_third;
    } cfg_t;

    // beat after face selection
    typedef struct packed {
        func_t       func;
        logic [2:0]  face;
        frac_t       s_a;
        frac_t       s_b;
        frac_t       s_c;
    } face_beat_t;

    // beat after offset build
    typedef struct packed {
        func_t             func;
        logic [2:0]        face;
        logic [2:0][32:0]  off;
        logic [2:0][18:0]  nrm;
    } off_beat_t;

    // result beat
    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [2:0]  face_index;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/obs_if.sv @@
// ============================================================================
// obs_if
// Valid/ready channels of the oriented box sampler: random draws in, samples
// out.
// ============================================================================
`default_nettype none

interface obs_draw_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] rand_a;
    logic [15:0] rand_b;
    logic [15:0] rand_c;

    modport source (output valid, func, rand_a, rand_b, rand_c, input ready);
    modport sink (input valid, func, rand_a, rand_b, rand_c, output ready);
endinterface

interface obs_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [2:0]  face_index;

    modport source (output valid, out_x, out_y, out_z, face_index, input ready);
    modport sink (input valid, out_x, out_y, out_z, face_index, output ready);
endinterface

`default_nettype wire

@@ hdl/obs_face.sv @@
// ============================================================================
// obs_face
// Two pipeline stages: scale rand_a to 0..599 and form the signed fractions,
// then reduce modulo 6 to the face number.
// ============================================================================
`default_nettype none

module obs_face (
    input  wire logic               clk,
    input  wire logic               rst_n,
    obs_draw_if.sink                draw,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output obs_pkg::face_beat_t     out_beat
);

    logic                 s1_valid_reg;
    logic                 s1_en;
    obs_pkg::func_t       s1_func_reg;
    logic [9:0]           s1_pos_reg;
    obs_pkg::frac_t       s1_s_a_reg;
    obs_pkg::frac_t       s1_s_b_reg;
    obs_pkg::frac_t       s1_s_c_reg;
    logic [25:0]          scaled;

    logic                 s2_valid_reg;
    logic                 s2_en;
    obs_pkg::face_beat_t  s2_beat_reg;
    obs_pkg::face_beat_t  s2_beat_next;
    logic [19:0]          quot_prod;
    logic [7:0]           quot;
    logic [9:0]           rem;

    // stall control, bubbles collapse
    assign s2_en      = !s2_valid_reg || out_ready;
    assign s1_en      = !s1_valid_reg || s2_en;
    assign draw.ready = s1_en;

    // floor(rand_a * 600 / 65536)
    assign scaled = 26'(draw.rand_a) * 26'd600;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= draw.valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // stage 1 payload; 2r-65536 is r doubled with the top bit flipped
    always_ff @(posedge clk)
    begin
        if (s1_en && draw.valid)
        begin
            s1_func_reg <= obs_pkg::func_t'(draw.func);
            s1_pos_reg  <= scaled[25:16];
            s1_s_a_reg  <= {~draw.rand_a[15], draw.rand_a[14:0], 1'b0};
            s1_s_b_reg  <= {~draw.rand_b[15], draw.rand_b[14:0], 1'b0};
            s1_s_c_reg  <= {~draw.rand_c[15], draw.rand_c[14:0], 1'b0};
        end
    end

    // modulo 6 by reciprocal: 683/4096 is exact for values below 600
    assign quot_prod = 20'(s1_pos_reg) * 20'd683;
    assign quot      = quot_prod[19:12];
    assign rem       = s1_pos_reg - 10'(quot) * 10'd6;

    always_comb
    begin
        s2_beat_next.func = s1_func_reg;
        s2_beat_next.face = rem[2:0];
        s2_beat_next.s_a  = s1_s_a_reg;
        s2_beat_next.s_b  = s1_s_b_reg;
        s2_beat_next.s_c  = s1_s_c_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_beat_reg <= s2_beat_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_beat  = s2_beat_reg;

endmodule

`default_nettype wire

@@ hdl/obs_offset.sv @@
// ============================================================================
// obs_offset
// One pipeline stage: builds the three local offsets (fraction times extent
// or a pinned face) and the signed face normal.
// ============================================================================
`default_nettype none

module obs_offset (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire obs_pkg::cfg_t        cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire obs_pkg::face_beat_t  in_beat,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output obs_pkg::off_beat_t        out_beat
);

    logic                valid_reg;
    logic                en;
    obs_pkg::off_beat_t  beat_reg;
    obs_pkg::off_beat_t  beat_next;
    logic [1:0]          ax;
    logic                surf;
    obs_pkg::frac_t      op [3];
    logic [2:0]          pinned;
    logic signed [33:0]  prod [3];
    obs_pkg::off_t       pin [3];
    logic [2:0][15:0]    nrm_axis;
    logic signed [18:0]  nrm_pos [3];

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    assign ax   = in_beat.face[2:1];
    assign surf = (in_beat.func == obs_pkg::FUNC_SURFACE);

    // operand choice: surface mode skips the pinned axis
    always_comb
    begin
        op[0]     = surf ? in_beat.s_b : in_beat.s_a;
        op[1]     = (surf && ax == 2'd2) ? in_beat.s_c : in_beat.s_b;
        op[2]     = in_beat.s_c;
        pinned[0] = surf && (ax == 2'd0);
        pinned[1] = surf && (ax == 2'd1);
        pinned[2] = surf && (ax == 2'd2);
    end

    // fraction times extent, or plus/minus extent on the chosen face
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod[k] = op[k] * $signed({1'b0, cfg.extent[k]});
            pin[k]  = in_beat.face[0] ? -$signed({1'b0, cfg.extent[k], 16'h0000})
                                      : $signed({1'b0, cfg.extent[k], 16'h0000});
        end
    end

    // axis of the face normal
    always_comb
    begin
        case (ax)
            2'd0:    nrm_axis = cfg.axis_first;
            2'd1:    nrm_axis = cfg.axis_second;
            default: nrm_axis = cfg.axis_third;
        endcase
    end

    // outgoing beat
    always_comb
    begin
        beat_next.func = in_beat.func;
        beat_next.face = in_beat.face;
        for (int k = 0; k < 3; k++)
        begin
            beat_next.off[k] = pinned[k] ? pin[k] : prod[k][32:0];
            nrm_pos[k]       = $signed({nrm_axis[k][15], nrm_axis[k], 2'b00});
            beat_next.nrm[k] = in_beat.face[0] ? -nrm_pos[k] : nrm_pos[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

`default_nettype wire

@@ hdl/obs_place.sv @@
// ============================================================================
// obs_place
// Three pipeline stages: nine offset-by-axis products, per-coordinate sum with
// the centre, then rounding to Q16.16 and result selection.
// ============================================================================
`default_nettype none

module obs_place (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire obs_pkg::cfg_t       cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire obs_pkg::off_beat_t  in_beat,
    obs_sample_if.source             sample
);

    logic                  p_valid_reg;
    logic                  p_en;
    obs_pkg::func_t        p_func_reg;
    logic [2:0]            p_face_reg;
    logic [2:0][18:0]      p_nrm_reg;
    obs_pkg::prod_t        p_prod_reg [3][3];
    logic [2:0][15:0]      axis_sel [3];

    logic                  a_valid_reg;
    logic                  a_en;
    obs_pkg::func_t        a_func_reg;
    logic [2:0]            a_face_reg;
    logic [2:0][18:0]      a_nrm_reg;
    obs_pkg::acc_t         a_acc_reg [3];
    obs_pkg::acc_t         acc_next [3];

    logic                  r_valid_reg;
    logic                  r_en;
    obs_pkg::res_t         res_reg;
    obs_pkg::res_t         res_next;
    obs_pkg::acc_t         biased [3];
    logic [31:0]           coord [3];
    logic [31:0]           nrm_ext [3];
    logic [31:0]           sel [3];

    // stall control
    assign r_en     = !r_valid_reg || sample.ready;
    assign a_en     = !a_valid_reg || r_en;
    assign p_en     = !p_valid_reg || a_en;
    assign in_ready = p_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_en)
            begin
                p_valid_reg <= in_valid;
            end
            if (a_en)
            begin
                a_valid_reg <= p_valid_reg;
            end
            if (r_en)
            begin
                r_valid_reg <= a_valid_reg;
            end
        end
    end

    // products: offset k times component c of axis k
    assign axis_sel[0] = cfg.axis_first;
    assign axis_sel[1] = cfg.axis_second;
    assign axis_sel[2] = cfg.axis_third;

    always_ff @(posedge clk)
    begin
        if (p_en && in_valid)
        begin
            p_func_reg <= in_beat.func;
            p_face_reg <= in_beat.face;
            p_nrm_reg  <= in_beat.nrm;
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p_prod_reg[c][k] <= 48'($signed(in_beat.off[k])
                                            * $signed(axis_sel[k][c]));
                end
            end
        end
    end

    // centre with 38 fraction bits plus the three products
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc_next[c] = 51'($signed(cfg.center[c])) * 51'sd1073741824
                        + 51'(p_prod_reg[c][0])
                        + 51'(p_prod_reg[c][1])
                        + 51'(p_prod_reg[c][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && p_valid_reg)
        begin
            a_func_reg <= p_func_reg;
            a_face_reg <= p_face_reg;
            a_nrm_reg  <= p_nrm_reg;
            for (int c = 0; c < 3; c++)
            begin
                a_acc_reg[c] <= acc_next[c];
            end
        end
    end

    // round half up to 16 fraction bits; the result always fits 32 bits
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            biased[c]  = a_acc_reg[c] + 51'sd2097152;
            coord[c]   = 32'(biased[c] >>> 22);
            nrm_ext[c] = 32'($signed(a_nrm_reg[c]));
        end
    end

    // pick point, normal or zero by function
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            case (a_func_reg)
                obs_pkg::FUNC_INTERIOR: sel[c] = coord[c];
                obs_pkg::FUNC_SURFACE:  sel[c] = coord[c];
                obs_pkg::FUNC_NORMAL:   sel[c] = nrm_ext[c];
                default:                sel[c] = 32'd0;
            endcase
        end
        res_next.out_x = sel[0];
        res_next.out_y = sel[1];
        res_next.out_z = sel[2];
        case (a_func_reg)
            obs_pkg::FUNC_SURFACE: res_next.face_index = a_face_reg;
            obs_pkg::FUNC_NORMAL:  res_next.face_index = a_face_reg;
            default:               res_next.face_index = 3'd0;
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (r_en && a_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign sample.valid      = r_valid_reg;
    assign sample.out_x      = res_reg.out_x;
    assign sample.out_y      = res_reg.out_y;
    assign sample.out_z      = res_reg.out_z;
    assign sample.face_index = res_reg.face_index;

endmodule

`default_nettype wire

@@ hdl/oriented_box_sampler_unit.sv @@
// Throughput: one beat per cycle unless stalled; six register stages (face
// scale, modulo 6, offset multiply, axis multiply, sum, round) each pass one
// beat a cycle unless a low sample.ready holds the output back.
// Reset: rst_n clears all stage valid bits and loads the box registers with
// centre 0, half sizes 0.5 and the identity axes; no clearing pass.
// ============================================================================
// oriented_box_sampler_unit
// Oriented box emitter sampler: interior points, surface points and face
// normals from three random fractions, with a plain register write port.
// ============================================================================
`default_nettype none

module oriented_box_sampler_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [obs_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  wire logic [obs_pkg::CfgDataWidth-1:0]      cfg_data,
    obs_draw_if.sink                                   draw,
    obs_sample_if.source                               sample
);

    obs_pkg::cfg_t        cfg_reg;
    logic                 face_valid;
    logic                 face_ready;
    obs_pkg::face_beat_t  face_beat;
    logic                 off_valid;
    logic                 off_ready;
    obs_pkg::off_beat_t   off_beat;

    // box registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center      <= obs_pkg::CENTER_RESET;
            cfg_reg.extent      <= obs_pkg::EXTENT_RESET;
            cfg_reg.axis_first  <= obs_pkg::AXIS_FIRST_RESET;
            cfg_reg.axis_second <= obs_pkg::AXIS_SECOND_RESET;
            cfg_reg.axis_third  <= obs_pkg::AXIS_THIRD_RESET;
        end
        else if (cfg_we)
        begin
            case (obs_pkg::reg_idx_t'(cfg_index))
                obs_pkg::REG_CENTER:      cfg_reg.center      <= cfg_data;
                obs_pkg::REG_EXTENT:      cfg_reg.extent      <= cfg_data;
                obs_pkg::REG_AXIS_FIRST:  cfg_reg.axis_first  <= cfg_data;
                obs_pkg::REG_AXIS_SECOND: cfg_reg.axis_second <= cfg_data;
                obs_pkg::REG_AXIS_THIRD:  cfg_reg.axis_third  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // face choice and fractions
    obs_face u_face (
        .clk       (clk),
        .rst_n     (rst_n),
        .draw      (draw),
        .out_valid (face_valid),
        .out_ready (face_ready),
        .out_beat  (face_beat)
    );

    // local offsets and normal
    obs_offset u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (face_valid),
        .in_ready  (face_ready),
        .in_beat   (face_beat),
        .out_valid (off_valid),
        .out_ready (off_ready),
        .out_beat  (off_beat)
    );

    // world placement and output register
    obs_place u_place (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (off_valid),
        .in_ready (off_ready),
        .in_beat  (off_beat),
        .sample   (sample)
    );

endmodule

`default_nettype wire
